/* hw/rtl/lfu_tbc_pkg.sv */
// Shared types and constants for the LFU translation block cache.
package lfu_tbc_pkg;

  localparam int ADDR_W       = 32;
  localparam int HITS_W       = 16;
  localparam int POS_W        = 5;
  localparam int DEF_CAPACITY = 32;
  localparam int OUT_W        = 56;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [HITS_W-1:0] hits;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  position;
    logic              evicted;
    logic [ADDR_W-1:0] evicted_addr;
    logic [HITS_W-1:0] hit_count;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIN,
    S_WALK,
    S_UPD
  } state_t;

endpackage

/* hw/rtl/lfu_tbc_cmp.sv */
// Shared compare unit: address match and hit-count less-than.
module lfu_tbc_cmp import lfu_tbc_pkg::*; (
  input  entry_t            entry,
  input  logic [ADDR_W-1:0] key,
  input  logic [HITS_W-1:0] min_hits,
  output logic              eq,
  output logic              lt
);

  assign eq = (entry.addr == key);
  assign lt = (entry.hits < min_hits);

endmodule

/* hw/rtl/lfu_tbc_core.sv */
// Entry memory and sequencer: min scan, shift/search walk, update.
module lfu_tbc_core import lfu_tbc_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] in_addr,
  output logic              res_load,
  output res_t              res,
  input  logic              res_free
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic              dv_r, dv_nxt;
  logic [IW-1:0]     d_idx_r, d_idx_nxt;
  logic [ADDR_W-1:0] key_r, key_nxt;
  logic [HITS_W-1:0] min_r, min_nxt;
  logic [IW-1:0]     victim_r, victim_nxt;
  logic [ADDR_W-1:0] vaddr_r, vaddr_nxt;
  logic              evict_r, evict_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     fpos_r, fpos_nxt;
  logic [HITS_W-1:0] fhits_r, fhits_nxt;

  logic              rd_en;
  logic [IW-1:0]     rd_idx;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  entry_t            wr_data;
  logic [CW-1:0]     len;
  logic [CW-1:0]     src;
  logic [HITS_W-1:0] fhits_sat;
  logic [IW-1:0]     pos_sel;
  logic              cmp_eq;
  logic              cmp_lt;

  lfu_tbc_cmp u_cmp (
    .entry    (rd_data_r),
    .key      (key_r),
    .min_hits (min_r),
    .eq       (cmp_eq),
    .lt       (cmp_lt)
  );

  assign len       = evict_r ? CAP_C - CW'(1) : cnt_r;
  assign src       = (evict_r && (i_r[IW-1:0] >= victim_r)) ? i_r + CW'(1) : i_r;
  assign fhits_sat = (fhits_r == HITS_MAX) ? fhits_r : fhits_r + HITS_W'(1);
  assign pos_sel   = found_r ? fpos_r : len[IW-1:0];
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    res.hit          = found_r;
    res.position     = POS_W'(pos_sel);
    res.evicted      = evict_r;
    res.evicted_addr = vaddr_r;
    res.hit_count    = found_r ? fhits_sat : '0;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    dv_nxt     = 1'b0;
    d_idx_nxt  = d_idx_r;
    key_nxt    = key_r;
    min_nxt    = min_r;
    victim_nxt = victim_r;
    vaddr_nxt  = vaddr_r;
    evict_nxt  = evict_r;
    found_nxt  = found_r;
    fpos_nxt   = fpos_r;
    fhits_nxt  = fhits_r;
    rd_en      = 1'b0;
    rd_idx     = i_r[IW-1:0];
    wr_en      = 1'b0;
    wr_idx     = d_idx_r;
    wr_data    = rd_data_r;
    res_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_addr;
          i_nxt     = '0;
          found_nxt = 1'b0;
          vaddr_nxt = '0;
          evict_nxt = (cnt_r == CAP_C);
          state_nxt = (cnt_r == CAP_C) ? S_MIN : S_WALK;
        end
      end
      S_MIN: begin
        if (dv_r && ((d_idx_r == '0) || cmp_lt)) begin
          min_nxt    = rd_data_r.hits;
          victim_nxt = d_idx_r;
          vaddr_nxt  = rd_data_r.addr;
        end
        if (i_r == CAP_C) begin
          i_nxt     = '0;
          state_nxt = S_WALK;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = i_r[IW-1:0];
          dv_nxt    = 1'b1;
          d_idx_nxt = i_r[IW-1:0];
          i_nxt     = i_r + CW'(1);
        end
      end
      S_WALK: begin
        if (dv_r) begin
          if (cmp_eq && !found_r) begin
            found_nxt = 1'b1;
            fpos_nxt  = d_idx_r;
            fhits_nxt = rd_data_r.hits;
          end
          // close the gap left by the victim
          if (evict_r && (d_idx_r >= victim_r)) begin
            wr_en = 1'b1;
          end
        end
        if (i_r == len) begin
          state_nxt = S_UPD;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = src[IW-1:0];
          dv_nxt    = 1'b1;
          d_idx_nxt = i_r[IW-1:0];
          i_nxt     = i_r + CW'(1);
        end
      end
      S_UPD: begin
        if (res_free) begin
          res_load = 1'b1;
          wr_en    = 1'b1;
          if (found_r) begin
            wr_idx       = fpos_r;
            wr_data.addr = key_r;
            wr_data.hits = fhits_sat;
            cnt_nxt      = len;
          end else begin
            wr_idx       = len[IW-1:0];
            wr_data.addr = key_r;
            wr_data.hits = '0;
            cnt_nxt      = len + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    d_idx_r  <= d_idx_nxt;
    key_r    <= key_nxt;
    min_r    <= min_nxt;
    victim_r <= victim_nxt;
    vaddr_r  <= vaddr_nxt;
    evict_r  <= evict_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
    fhits_r  <= fhits_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

endmodule

/* hw/rtl/lfu_translation_block_cache.sv */
// Top level of the LFU translation block cache with result register.
//
//   channel | dir | fields (tdata, low bit first)
//   in_     | in  | guest_pc[31:0]
//   out_    | out | hit, position[4:0], evicted, evicted_addr[31:0], hit_count[15:0], pad
//
// One transfer at a time. List not full: a shift/search walk over the entries,
// then the update step. List full: a min scan, then the shift/search walk, then
// the update step; the passes share the single read port of the entry memory.
// Reset empties the list at once; no clearing pass.
// A result not yet taken holds the sequencer in its update step.
module lfu_translation_block_cache import lfu_tbc_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // guest_pc
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // hit, position, evicted, evicted_addr, hit_count
);

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             res_load;
  logic             res_free;
  res_t             res;

  assign res_free = !out_valid_r || out_tready;

  lfu_tbc_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_addr  (in_tdata),
    .res_load (res_load),
    .res      (res),
    .res_free (res_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= {1'b0, res.hit_count, res.evicted_addr, res.evicted,
                     res.position, res.hit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/lfu_tbc_chk.sv */
// Port checker for the LFU translation block cache, bound to the top level.
module lfu_tbc_chk import lfu_tbc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [31:0]      in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input dropped or changed while stalled");

  a_no_evict_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[6] |-> out_tdata[38:7] == '0)
    else $error("evicted address nonzero without eviction");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[54:39] == '0)
    else $error("miss with nonzero hit count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind lfu_translation_block_cache lfu_tbc_chk u_chk (.*);
